// File: hw/rtl/smtu_pkg.sv
package smtu_pkg;

  // Default sizes of the timer pool and of the tick counter.
  localparam int NUM_SLOTS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  // Request codes.
  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ALLOC = 3'd1;
  localparam logic [2:0] REQ_FREE  = 3'd2;
  localparam logic [2:0] REQ_SET   = 3'd3;
  localparam logic [2:0] REQ_ARM   = 3'd4;

  // Slot status codes.
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_SCAN,
    S_UNLINK,
    S_ARM_WRITE,
    S_INSERT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic tick_inc;
    logic pop;
    logic scan_start;
    logic scan_step;
    logic reply;
    logic walk_start;
    logic unlink_step;
    logic free_write;
    logic set_write;
    logic arm_write;
    logic insert_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       slot_ok;
    logic       st_free;
    logic       st_run;
    logic       exp_hit;
    logic       scan_hit;
    logic       scan_end;
    logic       walk_end;
    logic       ins_stop;
    logic       out_busy;
  } sts_t;

endpackage

// File: hw/rtl/smtu_ctrl.sv
module smtu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  smtu_pkg::sts_t sts,
  output smtu_pkg::cmd_t cmd
);
  import smtu_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority case (sts.req_type)
          REQ_TICK:  state_next = S_POP;
          REQ_ALLOC: state_next = S_SCAN;
          REQ_FREE: begin
            if (sts.slot_ok && sts.st_run) state_next = S_UNLINK;
            else state_next = S_IDLE;
          end
          REQ_ARM: begin
            if (!sts.slot_ok || sts.st_free) state_next = S_IDLE;
            else if (sts.st_run) state_next = S_UNLINK;
            else state_next = S_ARM_WRITE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_POP: begin
        if (!sts.exp_hit) state_next = S_IDLE;
      end
      S_SCAN: begin
        if ((sts.scan_hit || sts.scan_end) && !sts.out_busy) state_next = S_IDLE;
      end
      S_UNLINK: begin
        if (sts.walk_end) begin
          if (sts.req_type == REQ_FREE) state_next = S_IDLE;
          else state_next = S_ARM_WRITE;
        end
      end
      S_ARM_WRITE: state_next = S_INSERT;
      S_INSERT: begin
        if (sts.ins_stop) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs. No request is taken while reset is held.
  always_comb begin
    cmd = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = !rst;
        cmd.load  = req_valid && !rst;
      end
      S_DECODE: begin
        priority case (sts.req_type)
          REQ_TICK:  cmd.tick_inc   = 1'b1;
          REQ_ALLOC: cmd.scan_start = 1'b1;
          REQ_FREE: begin
            if (sts.slot_ok && sts.st_run) cmd.walk_start = 1'b1;
            else if (sts.slot_ok) cmd.free_write = 1'b1;
          end
          REQ_SET:   cmd.set_write = sts.slot_ok;
          REQ_ARM: begin
            if (sts.slot_ok && sts.st_run) cmd.walk_start = 1'b1;
          end
          default: cmd = '0;
        endcase
      end
      S_POP: begin
        cmd.pop = sts.exp_hit && !sts.out_busy;
      end
      S_SCAN: begin
        if (sts.scan_hit || sts.scan_end) cmd.reply = !sts.out_busy;
        else cmd.scan_step = 1'b1;
      end
      S_UNLINK: begin
        cmd.unlink_step = 1'b1;
        cmd.free_write  = sts.walk_end && (sts.req_type == REQ_FREE);
      end
      S_ARM_WRITE: cmd.arm_write   = 1'b1;
      S_INSERT:    cmd.insert_step = 1'b1;
      default:     cmd = '0;
    endcase
  end

endmodule

// File: hw/rtl/smtu_datapath.sv
module smtu_datapath #(
  parameter int NUM_SLOTS  = smtu_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = smtu_pkg::COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [2:0]     req_type,
  input  logic [3:0]     slot,
  input  logic [3:0]     dest_queue,
  input  logic [31:0]    tag_data,
  input  logic [31:0]    delay_ticks,
  input  smtu_pkg::cmd_t cmd,
  output smtu_pkg::sts_t sts,
  output logic           res_valid,
  input  logic           res_ready,
  output logic           kind,
  output logic           ok,
  output logic [3:0]     slot_out,
  output logic [3:0]     dest_out,
  output logic [31:0]    data_out,
  output logic           last
);
  import smtu_pkg::*;

  localparam int ADDR_W = $clog2(NUM_SLOTS);
  localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [IDX_W-1:0] NIL = IDX_W'(NUM_SLOTS);

  logic [2:0]            rq_type;
  logic [3:0]            rq_slot;
  logic [3:0]            rq_dest;
  logic [31:0]           rq_tag;
  logic [31:0]           rq_delay;
  logic [COUNT_BITS-1:0] tick;
  logic [1:0]            status [NUM_SLOTS];
  logic [COUNT_BITS-1:0] deadline [NUM_SLOTS];
  logic [3:0]            dest_mem [NUM_SLOTS];
  logic [31:0]           tag_mem [NUM_SLOTS];
  logic [IDX_W-1:0]      nxt [NUM_SLOTS];
  logic [IDX_W-1:0]      head;
  logic [IDX_W-1:0]      cur;
  logic [IDX_W-1:0]      prev;
  logic [COUNT_BITS-1:0] dl_new;
  logic [ADDR_W-1:0]     scan_idx;

  logic [ADDR_W-1:0]     s_a;
  logic [ADDR_W-1:0]     head_a;
  logic [ADDR_W-1:0]     cur_a;
  logic [ADDR_W-1:0]     prev_a;
  logic [IDX_W-1:0]      head_next;
  logic [COUNT_BITS-1:0] arm_deadline;
  logic                  next_hit;

  assign s_a          = ADDR_W'(rq_slot);
  assign head_a       = head[ADDR_W-1:0];
  assign cur_a        = cur[ADDR_W-1:0];
  assign prev_a       = prev[ADDR_W-1:0];
  assign head_next    = nxt[head_a];
  assign arm_deadline = tick + COUNT_BITS'(rq_delay);
  assign next_hit     = (head_next != NIL) && (deadline[head_next[ADDR_W-1:0]] <= tick);

  // Status toward the controller.
  always_comb begin
    sts.req_type = rq_type;
    sts.slot_ok  = 32'(rq_slot) < 32'(NUM_SLOTS);
    sts.st_free  = status[s_a] == ST_FREE;
    sts.st_run   = status[s_a] == ST_RUN;
    sts.exp_hit  = (head != NIL) && (deadline[head_a] <= tick);
    sts.scan_hit = status[scan_idx] == ST_FREE;
    sts.scan_end = scan_idx == ADDR_W'(NUM_SLOTS - 1);
    sts.walk_end = (cur == NIL) || (cur_a == s_a);
    sts.ins_stop = (cur == NIL) || (deadline[cur_a] > dl_new);
    sts.out_busy = res_valid && !res_ready;
  end

  // Control state: counter, slot status, list head and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      head      <= NIL;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) status[i] <= ST_FREE;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.tick_inc) tick <= tick + 1'b1;
      if (cmd.pop) begin
        head           <= head_next;
        status[head_a] <= ST_ALLOC;
        res_valid      <= 1'b1;
      end
      if (cmd.reply) begin
        res_valid <= 1'b1;
        if (sts.scan_hit) status[scan_idx] <= ST_ALLOC;
      end
      if (cmd.free_write) status[s_a] <= ST_FREE;
      if (cmd.arm_write) status[s_a] <= ST_RUN;
      if (cmd.unlink_step && cur != NIL && cur_a == s_a && prev == NIL) head <= nxt[cur_a];
      if (cmd.insert_step && sts.ins_stop && prev == NIL) head <= IDX_W'(s_a);
    end
  end

  // Request capture, slot contents, list links, walk pointers and result fields.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_type  <= req_type;
      rq_slot  <= slot;
      rq_dest  <= dest_queue;
      rq_tag   <= tag_data;
      rq_delay <= delay_ticks;
    end
    if (cmd.set_write) begin
      dest_mem[s_a] <= rq_dest;
      tag_mem[s_a]  <= rq_tag;
    end
    if (cmd.scan_start) scan_idx <= '0;
    if (cmd.scan_step) scan_idx <= scan_idx + 1'b1;
    if (cmd.walk_start) begin
      prev <= NIL;
      cur  <= head;
    end
    if (cmd.unlink_step && cur != NIL) begin
      if (cur_a == s_a) begin
        if (prev != NIL) nxt[prev_a] <= nxt[cur_a];
      end else begin
        prev <= cur;
        cur  <= nxt[cur_a];
      end
    end
    if (cmd.arm_write) begin
      deadline[s_a] <= arm_deadline;
      dl_new        <= arm_deadline;
      prev          <= NIL;
      cur           <= head;
    end
    if (cmd.insert_step) begin
      if (sts.ins_stop) begin
        nxt[s_a] <= cur;
        if (prev != NIL) nxt[prev_a] <= IDX_W'(s_a);
      end else begin
        prev <= cur;
        cur  <= nxt[cur_a];
      end
    end
    if (cmd.pop) begin
      kind     <= 1'b1;
      ok       <= 1'b0;
      slot_out <= 4'(head_a);
      dest_out <= dest_mem[head_a];
      data_out <= tag_mem[head_a];
      last     <= !next_hit;
      nxt[head_a] <= NIL;
    end
    if (cmd.reply) begin
      kind     <= 1'b0;
      ok       <= sts.scan_hit;
      slot_out <= sts.scan_hit ? 4'(scan_idx) : 4'd0;
      dest_out <= 4'd0;
      data_out <= 32'd0;
      last     <= 1'b1;
    end
  end

endmodule

// File: hw/rtl/sorted_multi_timer_unit_top.sv
// Sorted timer pool with one request port and one result port. Each request
// is taken in the idle state and decoded in the decode state; a tick then
// pops each expired timer from the list head as a result transfer, allocate
// scans slot status one slot per cycle, and free or arm walk the deadline-ordered
// link list one entry per cycle, so an arm on a running slot walks it twice.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken.
module sorted_multi_timer_unit_top #(
  parameter int NUM_SLOTS  = smtu_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = smtu_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [2:0]  req_type,
  input  logic [3:0]  slot,
  input  logic [3:0]  dest_queue,
  input  logic [31:0] tag_data,
  input  logic [31:0] delay_ticks,
  output logic        res_valid,
  input  logic        res_ready,
  output logic        kind,
  output logic        ok,
  output logic [3:0]  slot_out,
  output logic [3:0]  dest_out,
  output logic [31:0] data_out,
  output logic        last
);
  import smtu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  smtu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Slot storage, list links and result register.
  smtu_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req_type    (req_type),
    .slot        (slot),
    .dest_queue  (dest_queue),
    .tag_data    (tag_data),
    .delay_ticks (delay_ticks),
    .cmd         (cmd),
    .sts         (sts),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .kind        (kind),
    .ok          (ok),
    .slot_out    (slot_out),
    .dest_out    (dest_out),
    .data_out    (data_out),
    .last        (last)
  );

endmodule

// File: hw/rtl/smtu_checker.sv
module smtu_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        kind,
  input logic        ok,
  input logic [3:0]  slot_out,
  input logic [3:0]  dest_out,
  input logic [31:0] data_out,
  input logic        last
);

  // A stalled result holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(data_out) && $stable(slot_out))
    else $error("stalled result changed");

  // One request at a time: no transfer right after a transfer.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // An allocate reply is always the only result of its request.
  a_alloc_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !kind |-> last)
    else $error("allocate reply not marked last");

  // An expiry never carries a grant.
  a_exp_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind |-> !ok)
    else $error("expiry with ok set");

  // A failed allocate reply carries zero fields.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !kind && !ok |-> slot_out == 4'd0 && dest_out == 4'd0 && data_out == 32'd0)
    else $error("failed allocate reply with nonzero fields");

endmodule

bind sorted_multi_timer_unit_top smtu_checker u_smtu_checker (.*);

// File: verif/tb_sorted_multi_timer_unit_top.sv
`timescale 1ns / 1ps

module tb_sorted_multi_timer_unit_top;
  import smtu_pkg::*;

  localparam int SLOTS = 16;
  localparam int END_MARK = SLOTS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 300;
  // First of the request codes that the block ignores.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic RES_ALLOC = 1'b0;
  localparam logic RES_EXPIRY = 1'b1;

  typedef struct {
    logic        kind;
    logic        ok;
    logic [3:0]  slot;
    logic [3:0]  dest;
    logic [31:0] data;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  logic [2:0]  req_type = REQ_TICK;
  logic [3:0]  slot = '0;
  logic [3:0]  dest_queue = '0;
  logic [31:0] tag_data = '0;
  logic [31:0] delay_ticks = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic        kind;
  logic        ok;
  logic [3:0]  slot_out;
  logic [3:0]  dest_out;
  logic [31:0] data_out;
  logic        last;

  // Shadow copy of the timer pool.
  logic [31:0] tick_now;
  logic [1:0]  slot_state [SLOTS];
  logic [31:0] slot_due [SLOTS];
  logic [3:0]  slot_queue [SLOTS];
  logic [31:0] slot_word [SLOTS];
  int          slot_link [SLOTS];
  int          due_head;
  bit          slot_loaded [SLOTS];

  timer_result_t pending_results[$];
  int fail_count = 0;
  int cycle_count = 0;

  sorted_multi_timer_unit_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_type    (req_type),
    .slot        (slot),
    .dest_queue  (dest_queue),
    .tag_data    (tag_data),
    .delay_ticks (delay_ticks),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .kind        (kind),
    .ok          (ok),
    .slot_out    (slot_out),
    .dest_out    (dest_out),
    .data_out    (data_out),
    .last        (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard limit on the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver rotates through three stall patterns: always ready, random, and a periodic pattern.
  always @(posedge clk) begin
    case ((cycle_count >> 8) % 3)
      0: res_ready <= 1'b1;
      1: res_ready <= 1'($urandom_range(0, 1));
      default: res_ready <= ((cycle_count % 7) < 4);
    endcase
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
             got, want);
    fail_count++;
  endtask

  // Compare each result transfer with the oldest expected result.
  always @(posedge clk) begin
    timer_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, slot", 32'(slot_out), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
        if (slot_out !== want.slot)
          report_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
        if (dest_out !== want.dest)
          report_mismatch("dest_out", 32'(dest_out), 32'(want.dest));
        if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
        if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
      end
    end
  end

  function automatic void clear_pool();
    tick_now = '0;
    due_head = END_MARK;
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = ST_FREE;
      slot_due[i] = '0;
      slot_queue[i] = '0;
      slot_word[i] = '0;
      slot_link[i] = END_MARK;
      slot_loaded[i] = 1'b0;
    end
  endfunction

  function automatic void detach_timer(input int s);
    int prev;
    int cur;
    int steps;
    prev = END_MARK;
    cur = due_head;
    steps = 0;
    while (cur < END_MARK && steps < SLOTS) begin
      if (cur == s) begin
        if (prev == END_MARK) due_head = slot_link[cur];
        else slot_link[prev] = slot_link[cur];
        break;
      end
      prev = cur;
      cur = slot_link[cur];
      steps++;
    end
    slot_link[s] = END_MARK;
  endfunction

  // Equal deadlines keep arming order: the new timer goes after them.
  function automatic void queue_timer(input int s);
    int prev;
    int cur;
    int steps;
    prev = END_MARK;
    cur = due_head;
    steps = 0;
    while (cur < END_MARK && steps < SLOTS) begin
      if (slot_due[cur] > slot_due[s]) break;
      prev = cur;
      cur = slot_link[cur];
      steps++;
    end
    slot_link[s] = cur;
    if (prev == END_MARK) due_head = s;
    else slot_link[prev] = s;
  endfunction

  // Apply one accepted request to the shadow pool and queue its results.
  function automatic void predict_timer_request(input logic [2:0] rt, input logic [3:0] s,
                                                input logic [3:0] dq,
                                                input logic [31:0] td,
                                                input logic [31:0] dt);
    timer_result_t r;
    int t;
    int n;
    case (rt)
      REQ_TICK: begin
        tick_now = tick_now + 32'd1;
        n = 0;
        while (due_head < END_MARK && slot_due[due_head] <= tick_now) begin
          t = due_head;
          due_head = slot_link[t];
          slot_link[t] = END_MARK;
          slot_state[t] = ST_ALLOC;
          r = '{RES_EXPIRY, 1'b0, 4'(t), slot_queue[t], slot_word[t], 1'b0};
          pending_results.push_back(r);
          n++;
        end
        if (n > 0) pending_results[pending_results.size() - 1].last = 1'b1;
      end
      REQ_ALLOC: begin
        r = '{RES_ALLOC, 1'b0, 4'd0, 4'd0, 32'd0, 1'b1};
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_state[i] == ST_FREE) begin
            slot_state[i] = ST_ALLOC;
            r.ok = 1'b1;
            r.slot = 4'(i);
            break;
          end
        end
        pending_results.push_back(r);
      end
      REQ_FREE: begin
        if (slot_state[s] == ST_RUN) detach_timer(s);
        slot_link[s] = END_MARK;
        slot_state[s] = ST_FREE;
      end
      REQ_SET: begin
        slot_queue[s] = dq;
        slot_word[s] = td;
        slot_loaded[s] = 1'b1;
      end
      REQ_ARM: begin
        if (slot_state[s] != ST_FREE) begin
          if (slot_state[s] == ST_RUN) detach_timer(s);
          slot_due[s] = tick_now + dt;
          slot_state[s] = ST_RUN;
          queue_timer(s);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Drive one request and hold it until the transfer. Valid stays high so
  // that a following request in the same step needs no second assignment.
  task automatic send_request(input logic [2:0] rt, input logic [3:0] s,
                              input logic [3:0] dq, input logic [31:0] td,
                              input logic [31:0] dt);
    req_valid <= 1'b1;
    req_type <= rt;
    slot <= s;
    dest_queue <= dq;
    tag_data <= td;
    delay_ticks <= dt;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_timer_request(rt, s, dq, td, dt);
  endtask

  task automatic pause_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every expected result has arrived and the block is idle.
  task automatic drain_results();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Ticks, extremes of the fields, equal deadlines, re-arm and ignored requests.
  task automatic test_directed();
    send_request(REQ_TICK, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_ALLOC, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_ALLOC, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_ALLOC, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_SET, 4'd0, 4'd15, 32'hFFFF_FFFF, 32'd0);
    send_request(REQ_SET, 4'd1, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_SET, 4'd2, 4'd10, 32'h1234_5678, 32'd0);
    send_request(REQ_ARM, 4'd0, 4'd0, 32'd0, 32'd2);
    send_request(REQ_ARM, 4'd1, 4'd0, 32'd0, 32'd2);
    send_request(REQ_ARM, 4'd2, 4'd0, 32'd0, 32'd0);
    send_request(REQ_ARM, 4'd3, 4'd0, 32'd0, 32'd0);
    send_request(REQ_UNUSED_LO, 4'd1, 4'd5, 32'hA5A5_A5A5, 32'd1);
    send_request(REQ_UNUSED_HI, 4'd15, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_FREE, 4'd15, 4'd0, 32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_ARM, 4'd0, 4'd0, 32'd0, 32'd5);
    send_request(REQ_ARM, 4'd0, 4'd0, 32'd0, 32'd1);
    send_request(REQ_SET, 4'd0, 4'd7, 32'hDEAD_BEEF, 32'd0);
    send_request(REQ_ARM, 4'd1, 4'd0, 32'd0, 32'hFFFF_FFFF);
    send_request(REQ_ARM, 4'd2, 4'd0, 32'd0, 32'd1);
    send_request(REQ_FREE, 4'd2, 4'd0, 32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0, 4'd0, 32'd0, 32'd0);
    send_request(REQ_TICK, 4'd0, 4'd0, 32'd0, 32'd0);
    drain_results();
  endtask

  // Allocate until the pool runs dry, then give every slot back.
  task automatic test_pool_exhaustion();
    for (int i = 0; i <= SLOTS; i++) send_request(REQ_ALLOC, 4'(i), 4'd0, 32'd0, 32'd0);
    for (int i = 0; i < SLOTS; i++) send_request(REQ_FREE, 4'(i), 4'd0, 32'd0, 32'd0);
    drain_results();
  endtask

  // Mostly sensible timer use with random content, plus some raw noise.
  task automatic test_random_traffic();
    logic [2:0]  rt;
    logic [3:0]  s;
    logic [31:0] dt;
    int pick;
    int burst_left;
    burst_left = $urandom_range(1, 20);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      s = 4'($urandom_range(0, SLOTS - 1));
      dt = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 6));
      if (pick < 15) rt = REQ_ALLOC;
      else if (pick < 30) rt = REQ_SET;
      else if (pick < 50) rt = REQ_ARM;
      else if (pick < 85) rt = REQ_TICK;
      else if (pick < 93) rt = REQ_FREE;
      else rt = 3'($urandom_range(0, 7));
      // Never arm a live slot whose destination and data were never written.
      if (rt == REQ_ARM && slot_state[s] != ST_FREE && !slot_loaded[s]) rt = REQ_SET;
      send_request(rt, s, 4'($urandom_range(0, 15)), $urandom(), dt);
      if (n == RANDOM_ITEMS / 2) drain_results();
      // Bursts with gaps, except for a stretch that runs back to back.
      if (n < 100 || n >= 150) begin
        burst_left--;
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, 10));
          burst_left = $urandom_range(1, 20);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    clear_pool();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_pool_exhaustion();
    test_random_traffic();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
